// ===== sv/image_filter_3x3_selectable_top_defines.svh =====
// Assertion macros for the 3x3 selectable image filter.
// Included by the top level; expects clk and rst in the including scope.
`ifndef IMAGE_FILTER_3X3_SELECTABLE_TOP_DEFINES_SVH
`define IMAGE_FILTER_3X3_SELECTABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define IMF3_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define IMF3_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/imf3_pkg.sv =====
// Shared types, constants and filter arithmetic for the 3x3 image filter.
// No dependencies.
`default_nettype none

package imf3_pkg;

  localparam int PIX_W      = 8;
  localparam int MODE_W     = 2;
  localparam int WREG_W     = 12;
  localparam int HREG_W     = 13;
  localparam int ROW_W      = 13;
  localparam int CNT_W      = 23;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam int DIV_CNT_W  = 5;

  localparam logic [WREG_W-1:0] W_MIN   = 12'd3;
  localparam logic [HREG_W-1:0] H_MIN   = 13'd3;
  localparam logic [HREG_W-1:0] H_MAX   = 13'd4096;
  localparam logic [WREG_W-1:0] W_RESET = 12'd640;
  localparam logic [HREG_W-1:0] H_RESET = 13'd480;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd23;

  localparam logic [MODE_W-1:0] MODE_MEAN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GAUSS = 2'd1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  // window[row][col], row 0 oldest line, col 2 newest column
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  // p / 9 for an 8-bit p: multiply by 57, drop nine bits
  function automatic logic [4:0] div9(input logic [PIX_W-1:0] p);
    logic [13:0] prod;
    prod = 14'(p) * 14'd57;
    return prod[13:9];
  endfunction

  function automatic logic [PIX_W-1:0] filter_win(input logic [MODE_W-1:0] mode,
                                                  input win_t q);
    logic [9:0]  s_mean;
    logic [9:0]  s_gauss;
    logic [11:0] lap;
    logic [11:0] mag;
    logic [PIX_W-1:0] res;
    s_mean = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        s_mean = s_mean + 10'(div9(q[r][c]));
      end
    end
    s_gauss = 10'(q[0][0] >> 4) + 10'(q[0][1] >> 3) + 10'(q[0][2] >> 4)
            + 10'(q[1][0] >> 3) + 10'(q[1][1] >> 2) + 10'(q[1][2] >> 3)
            + 10'(q[2][0] >> 4) + 10'(q[2][1] >> 3) + 10'(q[2][2] >> 4);
    lap = {2'b00, q[1][1], 2'b00} - 12'(q[0][1]) - 12'(q[2][1])
        - 12'(q[1][0]) - 12'(q[1][2]);
    mag = lap[11] ? (12'd0 - lap) : lap;
    if (mode[1]) begin
      res = mag[PIX_W-1:0];
    end else if (mode == MODE_GAUSS) begin
      res = s_gauss[PIX_W-1:0];
    end else begin
      res = s_mean[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/imf3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module imf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/image_filter_3x3_selectable_top.sv =====
// Top level of the 3x3 selectable image filter (mean, 1-2-1 Gaussian, Laplacian).
// Depends on imf3_pkg, imf3_ram and image_filter_3x3_selectable_top_defines.svh.
//
//  channel   handshake                      payload
//  -------   ---------------------------    ------------------------------------
//  input     s_axis_tvalid / s_axis_tready  tdata: pixel[7:0]; tuser: cmd
//  output    m_axis_tvalid / m_axis_tready  tdata: out_pixel[7:0]; tlast: out_last
//  config    cfg_we                         cfg_addr: register index; cfg_data
//
// One word enters per cycle while s_axis_tready is high; a result leaves once the word
// that completes its neighbourhood has passed the line-store read, then window and filter.
// Reset is synchronous: registers take 0 / 640 / 480, all counters clear, then
// every entry of both line stores is zeroed with s_axis_tready low.
// A width write holds s_axis_tready low for that cycle and while the restoring
// divider re-derives the output row and column from out_cnt; a stalled output holds
// the result, and the read stage behind it holds a word that would emit a result.
`default_nettype none
`include "image_filter_3x3_selectable_top_defines.svh"

module image_filter_3x3_selectable_top
  import imf3_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel
  input  wire logic                  s_axis_tuser,   // [0] cmd (1 = flush)
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [PIX_W-1:0]      m_axis_tdata,   // [7:0] out_pixel
  output logic                       m_axis_tlast,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // column index width, and a common width for column/width compares
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int XW = ((CW > WREG_W) ? CW : WREG_W) + 1;
  localparam logic [XW-1:0] MAXW_X =
    (MAX_WIDTH > 4095) ? XW'(4095) : XW'(MAX_WIDTH);
  localparam logic [CW-1:0] CLR_LAST = CW'(MAX_WIDTH - 1);

  // configuration registers
  logic [MODE_W-1:0] kernel_mode;
  logic [WREG_W-1:0] image_width;
  logic [HREG_W-1:0] image_height;
  logic [WREG_W-1:0] w_eff;
  logic [HREG_W-1:0] h_eff;
  logic [XW-1:0]     w_x;

  // frame counters
  logic [CW-1:0]    in_col;
  logic [ROW_W-1:0] in_row;
  logic [CW-1:0]    out_col;
  logic [ROW_W-1:0] out_row;
  logic [CNT_W-1:0] out_cnt;

  // line-store clearing pass after reset
  logic             clr_busy;
  logic [CW-1:0]    clr_addr;
  logic             ls_we;
  logic [CW-1:0]    ls_waddr;
  logic [PIX_W-1:0] up_wdata;
  logic [PIX_W-1:0] mid_wdata;

  // divider that re-derives out_row / out_col from out_cnt after a width write
  logic                 div_busy;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [WREG_W-1:0]    div_rem;
  logic [CNT_W-1:0]     div_quo;
  logic [WREG_W:0]      div_trial;
  logic                 div_ge;
  logic [WREG_W-1:0]    div_rem_next;
  logic [CNT_W-1:0]     div_quo_next;

  // line-store read stage
  logic             p1_valid;
  logic [PIX_W-1:0] p1_sample;
  logic [CW-1:0]    p1_col;
  logic             p1_emit;
  logic             p1_inner;
  logic             p1_last;
  logic             p1_adv;

  // window and result
  win_t             win;
  win_t             win_next;
  logic [PIX_W-1:0] up_rd;
  logic [PIX_W-1:0] mid_rd;
  logic             m_valid;
  logic [PIX_W-1:0] m_pixel;
  logic             m_last;

  // accept-stage decode
  logic             cfg_width_wr;
  logic             acc;
  logic             acc_item;
  logic             a_drain;
  logic             a_skip;
  logic [PIX_W-1:0] a_sample;
  logic             a_wrap0;
  logic [CW-1:0]    col0;
  logic [ROW_W-1:0] row0;
  logic             a_emit;
  logic             a_wrap1;
  logic [CW-1:0]    col_next;
  logic [ROW_W-1:0] row_next;
  logic             a_inner;
  logic             a_last;
  logic             o_wrap;
  logic [CW-1:0]    out_col_next;
  logic [ROW_W-1:0] out_row_next;
  logic             oc_ok;

  // clamp the size registers to their legal range
  always_comb begin
    if (image_width < W_MIN) begin
      w_eff = W_MIN;
    end else if (XW'(image_width) > MAXW_X) begin
      w_eff = MAXW_X[WREG_W-1:0];
    end else begin
      w_eff = image_width;
    end
    if (image_height < H_MIN) begin
      h_eff = H_MIN;
    end else if (image_height > H_MAX) begin
      h_eff = H_MAX;
    end else begin
      h_eff = image_height;
    end
    w_x = XW'(w_eff);
  end

  assign cfg_width_wr = cfg_we && (cfg_addr == REG_WIDTH);

  // pipeline advance: a non-emitting word leaves freely, else it needs the slot
  assign p1_adv = p1_valid && (!p1_emit || !m_valid || m_axis_tready);

  assign s_axis_tready = !clr_busy && !div_busy && !cfg_width_wr && (!p1_valid || p1_adv);
  assign acc      = s_axis_tvalid && s_axis_tready;

  // input side: position of this word, drain and flush handling
  always_comb begin
    a_drain  = (in_row >= h_eff);
    a_skip   = !a_drain && s_axis_tuser;
    a_sample = a_drain ? '0 : s_axis_tdata;
    a_wrap0  = (XW'(in_col) >= w_x);
    col0     = a_wrap0 ? '0 : in_col;
    row0     = a_wrap0 ? (in_row + 1'b1) : in_row;
    a_emit   = !((row0 == '0) || ((row0 == ROW_W'(1)) && (col0 == '0)));
    a_wrap1  = ((XW'(col0) + 1'b1) >= w_x);
    col_next = a_wrap1 ? '0 : (col0 + 1'b1);
    row_next = a_wrap1 ? (row0 + 1'b1) : row0;
  end

  assign acc_item = acc && !a_skip;

  // output side: border test and frame end from the output row / column
  always_comb begin
    a_inner = (out_row != '0) &&
              (({1'b0, out_row} + (ROW_W+1)'(2)) <= {1'b0, h_eff}) &&
              (out_col != '0) && ((XW'(out_col) + XW'(2)) <= w_x);
    a_last  = (out_row >= h_eff) ||
              ((out_row == (h_eff - 1'b1)) && (XW'(out_col) == (w_x - 1'b1)));
    o_wrap  = ((XW'(out_col) + 1'b1) >= w_x);
    out_col_next = o_wrap ? '0 : (out_col + 1'b1);
    if (o_wrap) begin
      out_row_next = (&out_row) ? out_row : (out_row + 1'b1);
    end else begin
      out_row_next = out_row;
    end
    oc_ok = (XW'(out_col) < w_x);
  end

  // one restoring step of out_cnt / w_eff
  always_comb begin
    div_trial    = {div_rem, div_quo[CNT_W-1]};
    div_ge       = (div_trial >= {1'b0, w_eff});
    div_rem_next = div_ge ? WREG_W'(div_trial - {1'b0, w_eff})
                          : div_trial[WREG_W-1:0];
    div_quo_next = {div_quo[CNT_W-2:0], div_ge};
  end

  // shift the window: new column from the two line stores and the sample
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win[r][1];
      win_next[r][1] = win[r][2];
    end
    win_next[0][2] = up_rd;
    win_next[1][2] = mid_rd;
    win_next[2][2] = p1_sample;
  end

  // line-store write port: zero fill after reset, else the advancing word
  assign ls_we     = clr_busy || p1_adv;
  assign ls_waddr  = clr_busy ? clr_addr : p1_col;
  assign up_wdata  = clr_busy ? '0 : mid_rd;
  assign mid_wdata = clr_busy ? '0 : p1_sample;

  imf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_upper (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_waddr),
    .wdata (up_wdata),
    .re    (acc_item),
    .raddr (col0),
    .rdata (up_rd)
  );

  imf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_middle (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_waddr),
    .wdata (mid_wdata),
    .re    (acc_item),
    .raddr (col0),
    .rdata (mid_rd)
  );

  // control: configuration, counters, divider, valids
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_mode  <= MODE_MEAN;
      image_width  <= W_RESET;
      image_height <= H_RESET;
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
      out_cnt      <= '0;
      clr_busy     <= 1'b1;
      clr_addr     <= '0;
      div_busy     <= 1'b0;
      div_cnt      <= '0;
      p1_valid     <= 1'b0;
      m_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          REG_MODE:   kernel_mode  <= cfg_data[MODE_W-1:0];
          REG_WIDTH:  image_width  <= cfg_data[WREG_W-1:0];
          REG_HEIGHT: image_height <= cfg_data[HREG_W-1:0];
          default: ;
        endcase
      end

      // advance the zero fill one entry per cycle, drop busy after the last
      if (clr_busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == CLR_LAST) begin
          clr_busy <= 1'b0;
        end
      end

      if (cfg_width_wr) begin
        div_busy <= 1'b1;
        div_cnt  <= DIV_STEPS;
      end else if (div_busy) begin
        div_cnt <= div_cnt - 1'b1;
        if (div_cnt == DIV_CNT_W'(1)) begin
          div_busy <= 1'b0;
          out_col  <= CW'(div_rem_next);
          out_row  <= (|div_quo_next[CNT_W-1:ROW_W]) ? '1
                                                     : div_quo_next[ROW_W-1:0];
        end
      end

      if (acc_item) begin
        if (a_emit && a_last) begin
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
          out_cnt <= '0;
        end else begin
          in_col <= col_next;
          in_row <= row_next;
          if (a_emit) begin
            out_col <= out_col_next;
            out_row <= out_row_next;
            out_cnt <= out_cnt + 1'b1;
          end
        end
      end

      if (acc_item) begin
        p1_valid <= 1'b1;
      end else if (p1_adv) begin
        p1_valid <= 1'b0;
      end

      if (p1_adv && p1_emit) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // payload: divider datapath, read stage, window and result word
  always_ff @(posedge clk) begin
    if (cfg_width_wr) begin
      div_rem <= '0;
      div_quo <= out_cnt;
    end else if (div_busy) begin
      div_rem <= div_rem_next;
      div_quo <= div_quo_next;
    end

    if (acc_item) begin
      p1_sample <= a_sample;
      p1_col    <= col0;
      p1_emit   <= a_emit;
      p1_inner  <= a_inner;
      p1_last   <= a_last;
    end

    if (p1_adv) begin
      win <= win_next;
    end

    if (p1_adv && p1_emit) begin
      // border pixels copy the centre unchanged
      m_pixel <= p1_inner ? filter_win(kernel_mode, win_next) : win_next[1][1];
      m_last  <= p1_last;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_pixel;
  assign m_axis_tlast  = m_last;

  `IMF3_ASSERT_IMP(a_div_blocks_input, div_busy, !s_axis_tready,
                   "input accepted while the divider runs")
  `IMF3_ASSERT_IMP(a_out_col_in_row, !div_busy, oc_ok,
                   "output column beyond the row width")
  `IMF3_ASSERT_NXT(a_stage_holds, p1_valid && p1_emit && m_valid && !m_axis_tready,
                   p1_valid, "read stage dropped a word behind a stalled output")
  `IMF3_ASSERT_NXT(a_frame_end_clears, acc_item && a_emit && a_last,
                   (in_row == '0) && (out_cnt == '0), "frame end left counters set")
  `IMF3_ASSERT_IMP(a_emit_after_first_row, acc_item && a_emit, row0 != '0,
                   "result produced during the first row")

endmodule

`default_nettype wire

// ===== tb/image_filter_3x3_selectable_top_tb.sv =====
// Self-checking testbench for the 3x3 selectable image filter top level.
// Needs imf3_pkg and image_filter_3x3_selectable_top; a scoreboard class
// predicts every filtered word from the accepted input stream.
`default_nettype none

module image_filter_3x3_selectable_top_tb
  import imf3_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_DEPTH   = 2048;
  localparam int unsigned SETTLE_CYC   = 32;        // covers the divider plus pipeline, with margin
  localparam int unsigned RANDOM_WORDS = 1500;
  localparam int unsigned CYCLE_LIMIT  = 1200000;
  localparam int unsigned REPORT_MAX   = 10;

  // Laplacian codes; any mode with bit 1 set selects it
  localparam logic [MODE_W-1:0] MODE_LAPLACE     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LAPLACE_ALT = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } pixel_result_t;

  // Scoreboard: tracks line stores, window and frame counters, and holds the
  // filtered words still owed by the block.
  class pixel_scoreboard;
    logic [MODE_W-1:0]  mode;
    logic [WREG_W-1:0]  width_reg;
    logic [HREG_W-1:0]  height_reg;
    logic [PIX_W-1:0]   upper_line [LINE_DEPTH];
    logic [PIX_W-1:0]   middle_line [LINE_DEPTH];
    logic [PIX_W-1:0]   win [3][3];
    int unsigned        col_in;
    int unsigned        row_in;
    logic [CNT_W-1:0]   out_idx;
    pixel_result_t      owed_pixels[$];
    int unsigned        n_errors;
    int unsigned        n_checked;

    function new();
      mode       = MODE_MEAN;
      width_reg  = W_RESET;
      height_reg = H_RESET;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win[r, c]) win[r][c] = '0;
      col_in    = 0;
      row_in    = 0;
      out_idx   = '0;
      n_errors  = 0;
      n_checked = 0;
    endfunction

    function int unsigned eff_w();
      if (width_reg < W_MIN) return W_MIN;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg < H_MIN) return H_MIN;
      if (height_reg > H_MAX) return H_MAX;
      return height_reg;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MODE:   mode       = val[MODE_W-1:0];
        REG_WIDTH:  width_reg  = val[WREG_W-1:0];
        REG_HEIGHT: height_reg = val[HREG_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return owed_pixels.size();
    endfunction

    // Filter the current window: mean and Gaussian terms each truncated on their own
    function logic [PIX_W-1:0] filtered_centre();
      int acc;
      acc = 0;
      if (mode[1]) begin
        acc = 4 * int'(win[1][1]) - int'(win[0][1]) - int'(win[2][1])
            - int'(win[1][0]) - int'(win[1][2]);
        if (acc < 0) acc = -acc;
      end else if (mode == MODE_GAUSS) begin
        acc = int'(win[0][0]) / 16 + (2 * int'(win[0][1])) / 16 + int'(win[0][2]) / 16
            + (2 * int'(win[1][0])) / 16 + (4 * int'(win[1][1])) / 16
            + (2 * int'(win[1][2])) / 16
            + int'(win[2][0]) / 16 + (2 * int'(win[2][1])) / 16 + int'(win[2][2]) / 16;
      end else begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            acc += int'(win[r][c]) / 9;
          end
        end
      end
      return acc[PIX_W-1:0];
    endfunction

    // Take one accepted input word; queue the filtered word it releases, if any
    function void absorb_word(bit flush, logic [PIX_W-1:0] pix);
      int unsigned   w;
      int unsigned   h;
      int unsigned   pos;
      int unsigned   col;
      int unsigned   k;
      int unsigned   r;
      int unsigned   c;
      logic [PIX_W-1:0] fresh;
      pixel_result_t res;
      w = eff_w();
      h = eff_h();
      if (row_in < h) begin
        if (flush) return;
        fresh = pix;
      end else begin
        fresh = '0;
      end
      if (col_in >= w) begin
        col_in = 0;
        row_in++;
      end
      pos = row_in * w + col_in;
      col = col_in % LINE_DEPTH;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2]        = upper_line[col];
      win[1][2]        = middle_line[col];
      win[2][2]        = fresh;
      upper_line[col]  = middle_line[col];
      middle_line[col] = fresh;
      col_in++;
      if (col_in >= w) begin
        col_in = 0;
        row_in++;
      end
      if (pos < w + 1) return;
      k = out_idx;
      r = k / w;
      c = k % w;
      if (r >= 1 && r + 2 <= h && c >= 1 && c + 2 <= w) begin
        res.pix = filtered_centre();
      end else begin
        res.pix = win[1][1];
      end
      res.last = (k + 1 >= h * w);
      out_idx  = CNT_W'(k + 1);
      if (res.last) begin
        col_in  = 0;
        row_in  = 0;
        out_idx = '0;
      end
      owed_pixels.push_back(res);
    endfunction

    function void check_pixel(logic [PIX_W-1:0] pix, logic last);
      pixel_result_t want;
      if (owed_pixels.size() == 0) begin
        n_errors++;
        if (n_errors <= REPORT_MAX)
          $display("unexpected output word: pixel %0d last %0b", pix, last);
        return;
      end
      want = owed_pixels.pop_front();
      if (pix !== want.pix || last !== want.last) begin
        n_errors++;
        if (n_errors <= REPORT_MAX)
          $display("output word %0d: expected pixel %0d last %0b, got pixel %0d last %0b",
                   n_checked, want.pix, want.last, pix, last);
      end
      n_checked++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata;   // [7:0] pixel
  logic                  s_axis_tuser;   // [0] cmd (1 = flush)
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [PIX_W-1:0]      m_axis_tdata;   // [7:0] out_pixel
  logic                  m_axis_tlast;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  pixel_scoreboard sb;
  bit              steady;        // when set, neither side idles
  int unsigned     cycle_count;

  image_filter_3x3_selectable_top #(
    .MAX_WIDTH(LINE_DEPTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: abandon the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Check every word that leaves the block; values read here are the ones
  // that stood before this edge, as the block saw them
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_pixel(m_axis_tdata, m_axis_tlast);
  end

  // Output side: draw a stall before each word, then hold tready high until
  // a word is taken
  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // Offer one input word after a random gap; tvalid stays high into the next
  // word when that word draws no gap, so it is never dropped and raised in one step
  task automatic send_word(bit flush, logic [PIX_W-1:0] pix);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= flush;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.absorb_word(flush, pix);
  endtask

  // Drop tvalid, wait for every owed word, then let the width divider and
  // any ignored flush clear the pipeline
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // One-cycle register write; the strobe drops on the following edge
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // A whole frame of random pixels with stray flushes during arrival, then a
  // drain of w+1 words mixing flushes and dropped pixels, sometimes a trailing
  // flush that the next frame ignores
  task automatic send_frame(int unsigned w, int unsigned h);
    int unsigned pick;
    logic [PIX_W-1:0] pix;
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 9) == 0) send_word(1'b1, PIX_W'($urandom));
      pick = $urandom_range(0, 7);
      pix  = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : PIX_W'($urandom);
      send_word(1'b0, pix);
    end
    for (int unsigned i = 0; i <= w; i++) send_word(1'($urandom), PIX_W'($urandom));
    if ($urandom_range(0, 3) == 0) send_word(1'b1, PIX_W'($urandom));
  endtask

  initial begin
    int unsigned random_words;
    sb            = new();
    steady        = 1'b0;
    random_words  = 0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_addr      <= REG_MODE;
    cfg_data      <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Mode three acts as Laplacian; sizes below three clamp up to a 3x3 frame.
    // Checkerboard of 0/255 gives the largest magnitude, folded to 8 bits.
    // A flush mid-frame is ignored; the drain mixes flushes with dropped pixels.
    write_reg(REG_MODE, {11'h000, MODE_LAPLACE_ALT});
    write_reg(REG_WIDTH, 13'd1);
    write_reg(REG_HEIGHT, 13'd2);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_word(1'b1, 8'h00);
      send_word(1'b0, (i % 2 == 0) ? 8'hFF : 8'h00);
    end
    send_word(1'b1, 8'h00);
    send_word(1'b0, 8'hAA);
    send_word(1'b1, 8'hFF);
    send_word(1'b0, 8'h55);

    // Gaussian over a flat white frame; junk above the mode bits is dropped
    settle();
    write_reg(REG_MODE, {11'h7FF, MODE_GAUSS});
    for (int i = 0; i < 9; i++) send_word(1'b0, 8'hFF);
    for (int i = 0; i < 4; i++) send_word(1'b1, 8'h00);

    // Select Laplacian and a small random frame size before the random part
    settle();
    write_reg(REG_MODE, {11'h000, MODE_LAPLACE});
    write_reg(REG_WIDTH, 13'($urandom_range(0, 12)));
    write_reg(REG_HEIGHT, 13'($urandom_range(0, 8)));

    // Random frames; about a third run back to back with no reconfiguration
    while (random_words < RANDOM_WORDS) begin
      if ($urandom_range(0, 2) != 0) begin
        settle();
        if ($urandom_range(0, 1) != 0) write_reg(REG_MODE, 13'($urandom));
        if ($urandom_range(0, 1) != 0)
          write_reg(REG_WIDTH, {1'($urandom), 12'($urandom_range(0, 12))});
        if ($urandom_range(0, 1) != 0) write_reg(REG_HEIGHT, 13'($urandom_range(0, 8)));
      end
      steady = ($urandom_range(0, 3) == 0);
      send_frame(sb.eff_w(), sb.eff_h());
      random_words += sb.eff_w() * sb.eff_h() + sb.eff_w() + 1;
    end

    settle();
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
